[rtl/core/ldr_pkg.sv]
`default_nettype none

package ldr_pkg;

   localparam int unsigned MAX_LOSS = 255;
   localparam int unsigned DEPTH = MAX_LOSS + 1;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned DATA_W = 32;
   localparam int unsigned FRAC_W = 31;

   localparam logic [DATA_W-1:0] ONE_Q31 = DATA_W'(1) << FRAC_W;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

endpackage

`default_nettype wire

[rtl/core/ldr_ram.sv]
`default_nettype none

module ldr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

[rtl/core/loss_distribution_recursion_unit.sv]
`default_nettype none

// Channel    Direction  Handshake             Word
// request    in         start & !busy         req_op, req_loss_amount, req_survival_prob,
//                                             req_read_index
// response   out        rsp_valid, one cycle  rsp_density_value, rsp_loss_span,
//                                             rsp_name_rejected
//
// Clear, refused add, zero-amount add and the unused op answer in the cycle after accept.
// A read steps through ST_READ_WAIT (for the registered RAM port) and ST_READ_DATA, then responds.
// An add of amount a on span s issues entries s+a down to 0 through the shared multiplier,
// one density entry per cycle, then drains through stage 1, stage 2 and the response register.
// Synchronous reset restores the point mass at loss 0 at once through per-entry valid
// bits; no clearing pass is needed. The receiver cannot stall the response strobe.

module loss_distribution_recursion_unit
   import ldr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_op,
   input  wire logic [7:0]        req_loss_amount,
   input  wire logic [31:0]       req_survival_prob,
   input  wire logic [7:0]        req_read_index,
   output logic                   rsp_valid,
   output logic      [31:0]       rsp_density_value,
   output logic      [7:0]        rsp_loss_span,
   output logic                   rsp_name_rejected
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_READ_DATA,
      ST_ADD_ISSUE,
      ST_ADD_DRAIN
   } state_type;

   state_type state_ff, state_in;

   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [ADDR_W-1:0] span_ff, span_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] amt_ff, amt_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   // Stage 1: RAM data arrives.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff, s1_last_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic              s1_lo_ok_ff, s1_lo_ok_in;
   logic              s1_vx_ff, s1_vx_in;
   logic              s1_vy_ff, s1_vy_in;
   logic              s1_y_at0_ff, s1_y_at0_in;

   // Stage 2: product registered, combine and write back.
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_last_ff, s2_last_in;
   logic [ADDR_W-1:0]          s2_addr_ff, s2_addr_in;
   logic [DATA_W-1:0]          s2_y_ff, s2_y_in;
   logic signed [2*DATA_W+1:0] prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ADDR_W-1:0] rsp_span_ff, rsp_span_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] rd_data_a, rd_data_b;
   logic              wr_en;
   logic [DATA_W-1:0] wr_data;

   logic [ADDR_W:0]            top_sum;
   logic [DATA_W-1:0]          p_sat;
   logic [ADDR_W-1:0]          k_lo;
   logic [DATA_W-1:0]          x_val, y_val;
   logic signed [DATA_W:0]     diff;
   logic signed [2*DATA_W+1:0] acc;

   ldr_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (s2_addr_ff),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   assign top_sum = {1'b0, span_ff} + {1'b0, req_loss_amount};
   assign p_sat   = (req_survival_prob > ONE_Q31) ? ONE_Q31 : req_survival_prob;
   assign k_lo    = k_ff - amt_ff;

   assign rd_addr_a = (state_ff == ST_ADD_ISSUE) ? k_ff : idx_ff;
   assign rd_addr_b = k_lo;

   // An entry never written since reset or clear holds the point mass value.
   always_comb begin
      x_val = s1_vx_ff ? rd_data_a : ((s1_addr_ff == '0) ? ONE_Q31 : '0);
      if (!s1_lo_ok_ff) begin
         y_val = '0;
      end else if (s1_vy_ff) begin
         y_val = rd_data_b;
      end else begin
         y_val = s1_y_at0_ff ? ONE_Q31 : '0;
      end
   end

   // p*x + q*y with q = 1 - p is rewritten as y*2^31 + p*(x - y): one multiply.
   assign diff    = $signed({1'b0, x_val}) - $signed({1'b0, y_val});
   assign acc     = $signed({3'b000, s2_y_ff, FRAC_W'(0)}) + prod_ff;
   assign wr_en   = s2_valid_ff;
   assign wr_data = acc[FRAC_W+DATA_W-1:FRAC_W];

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      span_in     = span_ff;
      top_in      = top_ff;
      amt_in      = amt_ff;
      p_in        = p_ff;
      k_in        = k_ff;
      idx_in      = idx_ff;

      s1_valid_in = 1'b0;
      s1_last_in  = 1'b0;
      s1_addr_in  = k_ff;
      s1_lo_ok_in = (k_ff >= amt_ff);
      s1_vx_in    = valid_ff[k_ff];
      s1_vy_in    = valid_ff[k_lo];
      s1_y_at0_in = (k_lo == '0);

      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_valid_ff & s1_last_ff;
      s2_addr_in  = s1_addr_ff;
      s2_y_in     = y_val;
      prod_in     = (2*DATA_W+2)'(diff) * (2*DATA_W+2)'($signed({1'b0, p_ff}));

      rsp_valid_in = 1'b0;
      rsp_value_in = '0;
      rsp_span_in  = span_ff;
      rsp_rej_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_op))
                  OP_CLEAR: begin
                     valid_in     = '0;
                     span_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_span_in  = '0;
                  end
                  OP_ADD: begin
                     if (top_sum > (ADDR_W+1)'(MAX_LOSS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_rej_in   = 1'b1;
                     end else if (req_loss_amount == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        amt_in   = req_loss_amount;
                        p_in     = p_sat;
                        top_in   = top_sum[ADDR_W-1:0];
                        k_in     = top_sum[ADDR_W-1:0];
                        state_in = ST_ADD_ISSUE;
                     end
                  end
                  OP_READ: begin
                     idx_in   = req_read_index;
                     state_in = ST_READ_WAIT;
                  end
                  OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = valid_ff[idx_ff] ? rd_data_a
                                            : ((idx_ff == '0) ? ONE_Q31 : '0);
            state_in     = ST_IDLE;
         end
         ST_ADD_ISSUE: begin
            s1_valid_in = 1'b1;
            s1_last_in  = (k_ff == '0);
            k_in        = k_ff - ADDR_W'(1);
            if (k_ff == '0) begin
               state_in = ST_ADD_DRAIN;
            end
         end
         ST_ADD_DRAIN: begin
            if (s2_last_ff) begin
               span_in      = top_ff;
               rsp_valid_in = 1'b1;
               rsp_span_in  = top_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (s2_valid_ff) begin
         valid_in[s2_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         span_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         span_ff      <= span_in;
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         s2_valid_ff  <= s2_valid_in;
         s2_last_ff   <= s2_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff       <= top_in;
      amt_ff       <= amt_in;
      p_ff         <= p_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      s1_addr_ff   <= s1_addr_in;
      s1_lo_ok_ff  <= s1_lo_ok_in;
      s1_vx_ff     <= s1_vx_in;
      s1_vy_ff     <= s1_vy_in;
      s1_y_at0_ff  <= s1_y_at0_in;
      s2_addr_ff   <= s2_addr_in;
      s2_y_ff      <= s2_y_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_span_ff  <= rsp_span_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_density_value = rsp_value_ff;
   assign rsp_loss_span     = rsp_span_ff;
   assign rsp_name_rejected = rsp_rej_ff;

endmodule

`default_nettype wire
